### rtl/core/periodic_image_radius_pair_filter_defines.svh
// Assertion macros shared by the periodic image radius pair filter RTL
`ifndef PERIODIC_IMAGE_RADIUS_PAIR_FILTER_DEFINES_SVH
`define PERIODIC_IMAGE_RADIUS_PAIR_FILTER_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define PIRPF_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define PIRPF_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/core/pirpf_pkg.sv
// Shared types, constants and helpers of the periodic image radius pair filter
package pirpf_pkg;

    localparam int COORD_WIDTH_DEF = 24;
    localparam int MAX_IMAGES_DEF  = 16;

    localparam int IMG_W      = 4;
    localparam int SLOT_W     = 4;
    localparam int PAIR_W     = 20;
    localparam int SHIFT_W    = 2;
    localparam int DIST_W     = 48;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 48;

    // Cell matrix entries per image and the fetch counter that walks them
    localparam int SLOT_COUNT = 9;
    localparam int FCNT_W     = 4;
    localparam int ROW_W      = 2;
    localparam logic [ROW_W-1:0] ROW_LAST = 2'd2;

    // Per-axis magnitude is clamped at 2^CLAMP_BITS before squaring
    localparam int CLAMP_BITS = 24;
    localparam int SQ_W       = 2 * (CLAMP_BITS + 1);

    localparam logic KIND_LOAD = 1'b0;
    localparam logic KIND_PAIR = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_RADIUS = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_REPS_X = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_REPS_Y = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_REPS_Z = 3'd4;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FETCH,
        ST_ISSUE,
        ST_WAIT,
        ST_JUDGE,
        ST_FLUSH
    } state_t;

    // Control flags of one row issue handed to the square-accumulate unit
    typedef struct packed {
        logic vld;
        logic first;
        logic last;
    } sqacc_ctl_t;

    function automatic logic signed [SHIFT_W-1:0] rep_low(input logic r);
        return r ? -2'sd1 : 2'sd0;
    endfunction

    function automatic logic signed [SHIFT_W-1:0] rep_high(input logic r);
        return r ? 2'sd1 : 2'sd0;
    endfunction

endpackage

### rtl/core/pirpf_ifs.sv
// Channel interfaces: item requests, result requests and configuration writes
interface pirpf_in_if #(
    parameter int COORD_WIDTH = pirpf_pkg::COORD_WIDTH_DEF
);
    import pirpf_pkg::*;

    logic                          valid;
    logic                          ready;
    logic                          kind;
    logic [IMG_W-1:0]              image;
    logic [SLOT_W-1:0]             cell_slot;
    logic signed [COORD_WIDTH-1:0] cell_value;
    logic [PAIR_W-1:0]             pair_index;
    logic signed [COORD_WIDTH-1:0] first_x;
    logic signed [COORD_WIDTH-1:0] first_y;
    logic signed [COORD_WIDTH-1:0] first_z;
    logic signed [COORD_WIDTH-1:0] second_x;
    logic signed [COORD_WIDTH-1:0] second_y;
    logic signed [COORD_WIDTH-1:0] second_z;

    modport source (
        output valid, kind, image, cell_slot, cell_value, pair_index,
               first_x, first_y, first_z, second_x, second_y, second_z,
        input  ready
    );
    modport sink (
        input  valid, kind, image, cell_slot, cell_value, pair_index,
               first_x, first_y, first_z, second_x, second_y, second_z,
        output ready
    );
endinterface

interface pirpf_out_if;
    import pirpf_pkg::*;

    logic                      valid;
    logic                      ready;
    logic [PAIR_W-1:0]         found_pair;
    logic signed [SHIFT_W-1:0] shift_i;
    logic signed [SHIFT_W-1:0] shift_j;
    logic signed [SHIFT_W-1:0] shift_k;
    logic [DIST_W-1:0]         distance_squared;
    logic                      last;

    modport source (
        output valid, found_pair, shift_i, shift_j, shift_k, distance_squared, last,
        input  ready
    );
    modport sink (
        input  valid, found_pair, shift_i, shift_j, shift_k, distance_squared, last,
        output ready
    );
endinterface

interface pirpf_cfg_if;
    import pirpf_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (
        output valid, index, data,
        input  ready
    );
    modport sink (
        input  valid, index, data,
        output ready
    );
endinterface

### rtl/core/periodic_image_radius_pair_filter.sv
// Top level: sequencer, configuration registers and result stage of the pair filter
//
//  port    dir   carries
//  ------  ----  -------------------------------------------------------------
//  cfg     in    register writes: index, data; always ready
//  item    in    cell loads (kind 0) and atom pairs (kind 1)
//  result  out   found_pair, shift_i/j/k, distance_squared, last
//
// A load request, or a pair whose image is out of range, leaves the sequencer idle.
// A pair walks N = (2*reps_x+1)(2*reps_y+1)(2*reps_z+1) shifts: it fetches
// its cell rows from the store, passes each shift through the shared
// add/square/accumulate unit (row issues, pipeline wait, judge), then flushes.
// item is ready only between pairs. A hit is held back until the next hit or flush
// so last can be marked; a full result register stalls the judge or flush step.
// Reset clears control, radius and min, sets reps to 1; the cell store is not cleared.
`include "periodic_image_radius_pair_filter_defines.svh"

module periodic_image_radius_pair_filter #(
    parameter int COORD_WIDTH = pirpf_pkg::COORD_WIDTH_DEF,
    parameter int MAX_IMAGES  = pirpf_pkg::MAX_IMAGES_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    pirpf_cfg_if.sink     cfg,
    pirpf_in_if.sink      item,
    pirpf_out_if.source   result
);
    import pirpf_pkg::*;

    localparam int DEPTH  = MAX_IMAGES * SLOT_COUNT;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int BASE_W = IMG_W + 4;

    // Configuration
    logic [DIST_W-1:0] radius_reg;
    logic [DIST_W-1:0] min_reg;
    logic              reps_x_reg;
    logic              reps_y_reg;
    logic              reps_z_reg;

    // Sequencer
    state_t                    state_reg;
    state_t                    state_next;
    logic [FCNT_W-1:0]         fcnt_reg;
    logic [ROW_W-1:0]          row_reg;
    logic signed [SHIFT_W-1:0] si_reg;
    logic signed [SHIFT_W-1:0] sj_reg;
    logic signed [SHIFT_W-1:0] sk_reg;
    logic [BASE_W-1:0]         img_base_reg;

    // Pair payload
    logic [PAIR_W-1:0]             pair_reg;
    logic signed [COORD_WIDTH:0]   base_reg [3];
    logic signed [COORD_WIDTH-1:0] cell_reg [SLOT_COUNT];

    // Held-back hit and result register
    logic                      pend_vld_reg;
    logic [PAIR_W-1:0]         pend_pair_reg;
    logic signed [SHIFT_W-1:0] pend_i_reg;
    logic signed [SHIFT_W-1:0] pend_j_reg;
    logic signed [SHIFT_W-1:0] pend_k_reg;
    logic [DIST_W-1:0]         pend_dist_reg;
    logic                      out_vld_reg;
    logic [PAIR_W-1:0]         out_pair_reg;
    logic signed [SHIFT_W-1:0] out_i_reg;
    logic signed [SHIFT_W-1:0] out_j_reg;
    logic signed [SHIFT_W-1:0] out_k_reg;
    logic [DIST_W-1:0]         out_dist_reg;
    logic                      out_last_reg;

    // Control decode
    logic       item_acc;
    logic       img_ok;
    logic       slot_ok;
    logic       pair_start;
    logic       mem_wr;
    logic       mem_rd;
    logic       shift_in;
    logic       issue;
    logic       judge_go;
    logic       judge_stall;
    logic       out_push;
    logic       out_free;
    logic       hit;
    logic       last_shift;
    sqacc_ctl_t issue_ctl;

    logic [BASE_W-1:0]             wr_addr_full;
    logic [BASE_W-1:0]             img_base;
    logic signed [COORD_WIDTH-1:0] rd_data;
    logic [SQ_W-1:0]               sq_sum;
    logic                          sq_done;

    // ------------------------------------------------------------------
    // Configuration port
    // ------------------------------------------------------------------
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_reg <= '0;
            min_reg    <= '0;
            reps_x_reg <= 1'b1;
            reps_y_reg <= 1'b1;
            reps_z_reg <= 1'b1;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                CFG_RADIUS: radius_reg <= cfg.data;
                CFG_MIN:    min_reg    <= cfg.data;
                CFG_REPS_X: reps_x_reg <= cfg.data[0];
                CFG_REPS_Y: reps_y_reg <= cfg.data[0];
                CFG_REPS_Z: reps_z_reg <= cfg.data[0];
                default:    ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Request decode
    // ------------------------------------------------------------------
    assign item_acc   = item.valid && item.ready;
    assign img_ok     = int'(item.image) < MAX_IMAGES;
    assign slot_ok    = int'(item.cell_slot) < SLOT_COUNT;
    assign pair_start = item_acc && (item.kind == KIND_PAIR) && img_ok;
    assign mem_wr     = item_acc && (item.kind == KIND_LOAD) && img_ok && slot_ok;

    // image * 9 as shift and add
    assign img_base     = BASE_W'({item.image, 3'b000}) + BASE_W'(item.image);
    assign wr_addr_full = img_base + BASE_W'(item.cell_slot);

    // Shift walk in raster order, k innermost
    assign last_shift = (si_reg == rep_high(reps_x_reg))
                     && (sj_reg == rep_high(reps_y_reg))
                     && (sk_reg == rep_high(reps_z_reg));

    // min < sum <= radius; sum carries two guard bits above the registers
    assign hit = (sq_sum <= SQ_W'(radius_reg)) && (sq_sum > SQ_W'(min_reg));

    assign out_free    = !out_vld_reg || result.ready;
    assign judge_stall = hit && pend_vld_reg && !out_free;

    // ------------------------------------------------------------------
    // Sequencer: next state
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (pair_start)
                begin
                    state_next = ST_FETCH;
                end
            end
            ST_FETCH:
            begin
                if (fcnt_reg == FCNT_W'(SLOT_COUNT))
                begin
                    state_next = ST_ISSUE;
                end
            end
            ST_ISSUE:
            begin
                if (row_reg == ROW_LAST)
                begin
                    state_next = ST_WAIT;
                end
            end
            ST_WAIT:
            begin
                if (sq_done)
                begin
                    state_next = ST_JUDGE;
                end
            end
            ST_JUDGE:
            begin
                if (!judge_stall)
                begin
                    state_next = last_shift ? ST_FLUSH : ST_ISSUE;
                end
            end
            ST_FLUSH:
            begin
                if (!pend_vld_reg || out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Sequencer: outputs
    // ------------------------------------------------------------------
    always_comb
    begin
        item.ready = 1'b0;
        mem_rd     = 1'b0;
        shift_in   = 1'b0;
        issue      = 1'b0;
        judge_go   = 1'b0;
        out_push   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                item.ready = 1'b1;
            end
            ST_FETCH:
            begin
                mem_rd   = fcnt_reg != FCNT_W'(SLOT_COUNT);
                shift_in = fcnt_reg != '0;
            end
            ST_ISSUE:
            begin
                issue = 1'b1;
            end
            ST_JUDGE:
            begin
                judge_go = !judge_stall;
                out_push = !judge_stall && hit && pend_vld_reg;
            end
            ST_FLUSH:
            begin
                out_push = pend_vld_reg && out_free;
            end
            default:
            begin
                item.ready = 1'b0;
            end
        endcase
    end

    assign issue_ctl.vld   = issue;
    assign issue_ctl.first = row_reg == '0;
    assign issue_ctl.last  = row_reg == ROW_LAST;

    // ------------------------------------------------------------------
    // Control registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            fcnt_reg     <= '0;
            row_reg      <= '0;
            si_reg       <= '0;
            sj_reg       <= '0;
            sk_reg       <= '0;
            pend_vld_reg <= 1'b0;
            out_vld_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (pair_start)
            begin
                fcnt_reg <= '0;
                row_reg  <= '0;
                si_reg   <= rep_low(reps_x_reg);
                sj_reg   <= rep_low(reps_y_reg);
                sk_reg   <= rep_low(reps_z_reg);
            end
            else if (state_reg == ST_FETCH)
            begin
                fcnt_reg <= fcnt_reg + FCNT_W'(1);
            end

            if (issue)
            begin
                row_reg <= (row_reg == ROW_LAST) ? '0 : row_reg + ROW_W'(1);
            end

            if (judge_go && !last_shift)
            begin
                if (sk_reg != rep_high(reps_z_reg))
                begin
                    sk_reg <= sk_reg + SHIFT_W'(1);
                end
                else
                begin
                    sk_reg <= rep_low(reps_z_reg);
                    if (sj_reg != rep_high(reps_y_reg))
                    begin
                        sj_reg <= sj_reg + SHIFT_W'(1);
                    end
                    else
                    begin
                        sj_reg <= rep_low(reps_y_reg);
                        si_reg <= si_reg + SHIFT_W'(1);
                    end
                end
            end

            if (judge_go && hit)
            begin
                pend_vld_reg <= 1'b1;
            end
            else if (state_reg == ST_FLUSH && out_push)
            begin
                pend_vld_reg <= 1'b0;
            end

            if (out_push)
            begin
                out_vld_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Payload registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (pair_start)
        begin
            pair_reg     <= item.pair_index;
            img_base_reg <= img_base;
            base_reg[0]  <= (COORD_WIDTH+1)'(item.second_x) - (COORD_WIDTH+1)'(item.first_x);
            base_reg[1]  <= (COORD_WIDTH+1)'(item.second_y) - (COORD_WIDTH+1)'(item.first_y);
            base_reg[2]  <= (COORD_WIDTH+1)'(item.second_z) - (COORD_WIDTH+1)'(item.first_z);
        end
        else if (issue)
        begin
            // rotate so the row in use always sits at the front
            base_reg[0] <= base_reg[1];
            base_reg[1] <= base_reg[2];
            base_reg[2] <= base_reg[0];
        end

        if (shift_in)
        begin
            // slot 0 ends up in front after nine reads
            for (int n = 0; n < SLOT_COUNT - 1; n++)
            begin
                cell_reg[n] <= cell_reg[n+1];
            end
            cell_reg[SLOT_COUNT-1] <= rd_data;
        end
        else if (issue)
        begin
            for (int n = 0; n < SLOT_COUNT; n++)
            begin
                cell_reg[n] <= cell_reg[(n + 3) % SLOT_COUNT];
            end
        end

        if (judge_go && hit)
        begin
            pend_pair_reg <= pair_reg;
            pend_i_reg    <= si_reg;
            pend_j_reg    <= sj_reg;
            pend_k_reg    <= sk_reg;
            pend_dist_reg <= DIST_W'(sq_sum);
        end

        if (out_push)
        begin
            out_pair_reg <= pend_pair_reg;
            out_i_reg    <= pend_i_reg;
            out_j_reg    <= pend_j_reg;
            out_k_reg    <= pend_k_reg;
            out_dist_reg <= pend_dist_reg;
            out_last_reg <= state_reg == ST_FLUSH;
        end
    end

    assign result.valid            = out_vld_reg;
    assign result.found_pair       = out_pair_reg;
    assign result.shift_i          = out_i_reg;
    assign result.shift_j          = out_j_reg;
    assign result.shift_k          = out_k_reg;
    assign result.distance_squared = out_dist_reg;
    assign result.last             = out_last_reg;

    // ------------------------------------------------------------------
    // Cell store and shared row unit
    // ------------------------------------------------------------------
    pirpf_cell_mem #(
        .DEPTH       (DEPTH),
        .COORD_WIDTH (COORD_WIDTH),
        .ADDR_W      (ADDR_W)
    ) u_cell_mem (
        .clk     (clk),
        .wr_en   (mem_wr),
        .wr_addr (ADDR_W'(wr_addr_full)),
        .wr_data (item.cell_value),
        .rd_en   (mem_rd),
        .rd_addr (ADDR_W'(img_base_reg + BASE_W'(fcnt_reg))),
        .rd_data (rd_data)
    );

    pirpf_sqacc #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_sqacc (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctl    (issue_ctl),
        .base   (base_reg[0]),
        .cell_a (cell_reg[0]),
        .cell_b (cell_reg[1]),
        .cell_c (cell_reg[2]),
        .rep_i  (si_reg),
        .rep_j  (sj_reg),
        .rep_k  (sk_reg),
        .sum    (sq_sum),
        .done   (sq_done)
    );

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `PIRPF_ASSERT_IMP(a_done_in_wait, sq_done, state_reg == ST_WAIT, "row sum done outside wait")
    `PIRPF_ASSERT_IMP(a_push_has_pend, out_push, pend_vld_reg, "result pushed with nothing held")
    `PIRPF_ASSERT_IMP(a_idle_no_pend, state_reg == ST_IDLE, !pend_vld_reg, "hit left over in idle")
    `PIRPF_ASSERT_NXT(a_flush_marks_last, out_push && state_reg == ST_FLUSH, result.last,
        "final result of a pair not marked last")

endmodule

### rtl/core/pirpf_cell_mem.sv
// Cell matrix store: one write port, one registered read port
module pirpf_cell_mem #(
    parameter int DEPTH       = pirpf_pkg::MAX_IMAGES_DEF * pirpf_pkg::SLOT_COUNT,
    parameter int COORD_WIDTH = pirpf_pkg::COORD_WIDTH_DEF,
    parameter int ADDR_W      = $clog2(DEPTH)
) (
    input  logic                          clk,
    input  logic                          wr_en,
    input  logic [ADDR_W-1:0]             wr_addr,
    input  logic signed [COORD_WIDTH-1:0] wr_data,
    input  logic                          rd_en,
    input  logic [ADDR_W-1:0]             rd_addr,
    output logic signed [COORD_WIDTH-1:0] rd_data
);
    import pirpf_pkg::*;

    logic signed [COORD_WIDTH-1:0] mem [DEPTH];
    logic signed [COORD_WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### rtl/core/pirpf_sqacc.sv
// Shared row unit: offset add, clamp, square and accumulate over three rows
module pirpf_sqacc #(
    parameter int COORD_WIDTH = pirpf_pkg::COORD_WIDTH_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  pirpf_pkg::sqacc_ctl_t           ctl,
    input  logic signed [COORD_WIDTH:0]     base,
    input  logic signed [COORD_WIDTH-1:0]   cell_a,
    input  logic signed [COORD_WIDTH-1:0]   cell_b,
    input  logic signed [COORD_WIDTH-1:0]   cell_c,
    input  logic signed [pirpf_pkg::SHIFT_W-1:0] rep_i,
    input  logic signed [pirpf_pkg::SHIFT_W-1:0] rep_j,
    input  logic signed [pirpf_pkg::SHIFT_W-1:0] rep_k,
    output logic [pirpf_pkg::SQ_W-1:0]      sum,
    output logic                            done
);
    import pirpf_pkg::*;

    // base + three scaled cells stays below 2.5 * 2^CW in magnitude
    localparam int DW    = COORD_WIDTH + 3;
    localparam int MAG_W = (DW > CLAMP_BITS + 1) ? DW : CLAMP_BITS + 1;
    localparam int CW_B  = CLAMP_BITS + 1;
    localparam logic [MAG_W-1:0] CLAMP_LIM = MAG_W'(1) << CLAMP_BITS;

    sqacc_ctl_t           a_ctl_reg;
    sqacc_ctl_t           b_ctl_reg;
    logic signed [DW-1:0] d_reg;
    logic [SQ_W-1:0]      sq_reg;
    logic [SQ_W-1:0]      acc_reg;
    logic                 done_reg;

    logic signed [DW-1:0] sc_a;
    logic signed [DW-1:0] sc_b;
    logic signed [DW-1:0] sc_c;
    logic signed [DW-1:0] d_next;
    logic [DW-1:0]        mag;
    logic [MAG_W-1:0]     mag_ext;
    logic [CW_B-1:0]      mag_c;

    // Repetition is -1, 0 or +1: negate, zero or pass the cell entry
    always_comb
    begin
        sc_a = (rep_i == '0) ? '0 : (rep_i[SHIFT_W-1] ? -DW'(cell_a) : DW'(cell_a));
        sc_b = (rep_j == '0) ? '0 : (rep_j[SHIFT_W-1] ? -DW'(cell_b) : DW'(cell_b));
        sc_c = (rep_k == '0) ? '0 : (rep_k[SHIFT_W-1] ? -DW'(cell_c) : DW'(cell_c));
        d_next = DW'(base) + sc_a + sc_b + sc_c;
    end

    always_comb
    begin
        mag     = d_reg[DW-1] ? DW'(-d_reg) : DW'(d_reg);
        mag_ext = MAG_W'(mag);
        mag_c   = (mag_ext > CLAMP_LIM) ? CW_B'(CLAMP_LIM) : CW_B'(mag_ext);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_ctl_reg <= '0;
            b_ctl_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            a_ctl_reg <= ctl;
            b_ctl_reg <= a_ctl_reg;
            done_reg  <= b_ctl_reg.vld && b_ctl_reg.last;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.vld)
        begin
            d_reg <= d_next;
        end
        if (a_ctl_reg.vld)
        begin
            sq_reg <= SQ_W'(mag_c) * SQ_W'(mag_c);
        end
        if (b_ctl_reg.vld)
        begin
            acc_reg <= b_ctl_reg.first ? sq_reg : acc_reg + sq_reg;
        end
    end

    assign sum  = acc_reg;
    assign done = done_reg;

endmodule
